// ----- src/alp_pkg.sv -----
`default_nettype none

package alp_pkg;

	// One table node: cumulative distance (unsigned Q16.16) and coordinates (signed Q16.16).
	typedef struct packed {
		logic        [31:0] cum_dist;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} node_t;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_BEYOND = 2'd1;
	localparam logic [1:0] STATUS_DEGEN  = 2'd2;

	// Fraction value 1.0 in Q16.
	localparam logic [16:0] FRAC_ONE = 17'h10000;

endpackage

`default_nettype wire

// ----- src/arc_length_point_locator.sv -----
`default_nettype none

// Arc-length point locator for a polyline held in an on-chip node table.
// Command channel: an item is taken when start is high and busy is low.
//   mode 0 writes one node (distance, x, y, z) to slot node_index; busy never
//   rises and no result follows.
//   mode 1 locates query_distance: busy stays high until the result transfer.
// Result channel: done pulses for one cycle with element_index, point_x/y/z and
//   status; the receiver cannot stall, the fields hold until the next result.
// Locate sequence (each node table read goes through a registered RAM port and
//   a wait state): last-node check, binary search steps (up to
//   ceil(log2(element_count)) steps), fetch of the element's two nodes, the
//   bit-serial fraction divider (16 quotient bits) and the shared multiplier
//   for the three axes. A saturated fraction skips the divider loop; a
//   degenerate element ends after the node fetch; a beyond-length query ends
//   after the last-node check.
// Configuration: APB register 0 (element_count) at byte address 0; the user
// writes it only while idle, and the block itself does not enforce this.
// Reset clears control state and sets element_count to 1; the node table
// is not cleared and must be loaded before use.
module arc_length_point_locator
	import alp_pkg::*;
#(
	parameter int MAX_NODES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command channel
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               mode,
	input  wire logic        [9:0]  node_index,
	input  wire logic        [31:0] node_distance,
	input  wire logic signed [31:0] node_x,
	input  wire logic signed [31:0] node_y,
	input  wire logic signed [31:0] node_z,
	input  wire logic        [31:0] query_distance,
	// result channel
	output logic                    done,
	output logic             [9:0]  element_index,
	output logic signed      [31:0] point_x,
	output logic signed      [31:0] point_y,
	output logic signed      [31:0] point_z,
	output logic             [1:0]  status,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic        [2:0]  paddr,
	input  wire logic        [31:0] pwdata,
	output logic             [31:0] prdata,
	output logic                    pready
);

	localparam int          AW       = $clog2(MAX_NODES);
	localparam logic [16:0] NMAX     = 17'(MAX_NODES - 1);
	localparam logic [16:0] NDEPTH   = 17'(MAX_NODES);
	localparam logic        REG_ELEM = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAIT,
		S_CHECK,
		S_SEARCH,
		S_TOP,
		S_BOT,
		S_DIV,
		S_LERP
	} state_t;

	state_t          state_q;
	state_t          ret_q;
	logic [9:0]      elem_cnt_q;
	logic [AW-1:0]   raddr_q;
	logic [AW-1:0]   n_q;
	logic [AW-1:0]   top_q;
	logic [AW-1:0]   bot_q;
	logic [AW-1:0]   mid_q;
	logic [31:0]     query_q;
	node_t           lo_q;
	node_t           hi_q;
	logic [31:0]     off_q;
	logic [31:0]     len_q;
	logic            div_start_q;
	logic            lerp_start_q;

	node_t           rdata;
	node_t           wdata;
	logic            we;
	logic [16:0]     waddr_ext;
	logic [16:0]     cnt_ext;
	logic [16:0]     n_ext;
	logic [AW-1:0]   n_c;

	logic [AW-1:0]   nt;
	logic [AW-1:0]   nb;
	logic [AW:0]     msum;
	logic [AW-1:0]   nmid;
	logic [32:0]     len_c;
	logic [32:0]     off_c;
	logic            degen;
	logic [31:0]     top_ext;

	logic            div_done;
	logic [16:0]     frac;
	logic            lerp_done;
	logic [31:0]     px;
	logic [31:0]     py;
	logic [31:0]     pz;

	logic            cfg_wr;

	// ---------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_ELEM) ? 32'(elem_cnt_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= 10'd1;
		end else if (cfg_wr && paddr[2] == REG_ELEM) begin
			elem_cnt_q <= pwdata[9:0];
		end
	end

	// ---------------------------------------------------------------------
	// Node table; loads bypass the sequencer
	// ---------------------------------------------------------------------
	assign busy      = (state_q != S_IDLE);
	assign waddr_ext = 17'(node_index);
	assign we        = start && !busy && !mode && (waddr_ext < NDEPTH);
	assign wdata     = '{cum_dist: node_distance, x: node_x, y: node_y, z: node_z};

	alp_node_ram #(
		.MAX_NODES(MAX_NODES),
		.AW       (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr_ext[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr_q),
		.rdata(rdata)
	);

	// element count clamped to 1..MAX_NODES-1
	always_comb begin
		cnt_ext = 17'(elem_cnt_q);
		n_ext   = (cnt_ext == 17'd0) ? 17'd1 : cnt_ext;
		if (n_ext > NMAX) begin
			n_ext = NMAX;
		end
		n_c = n_ext[AW-1:0];
	end

	// search step: narrow [top, bot] after a compare, then pick the next probe
	always_comb begin
		if (state_q == S_CHECK) begin
			nt = '0;
			nb = n_q - AW'(1);
		end else if (rdata.cum_dist < query_q) begin
			nt = mid_q + AW'(1);
			nb = bot_q;
		end else begin
			nt = top_q;
			nb = mid_q;
		end
		msum = {1'b0, nt} + {1'b0, nb};
		nmid = msum[AW:1];
	end

	// element length and offset from the element's top node
	always_comb begin
		len_c   = {1'b0, rdata.cum_dist} - {1'b0, lo_q.cum_dist};
		off_c   = {1'b0, query_q} - {1'b0, lo_q.cum_dist};
		degen   = len_c[32] || (len_c == 33'd0) || off_c[32];
		top_ext = 32'(top_q);
	end

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			div_start_q  <= 1'b0;
			lerp_start_q <= 1'b0;
			done         <= 1'b0;
			status       <= STATUS_OK;
		end else begin
			done         <= 1'b0;
			div_start_q  <= 1'b0;
			lerp_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && mode) begin
						query_q <= query_distance;
						n_q     <= n_c;
						raddr_q <= n_c;
						ret_q   <= S_CHECK;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= ret_q;
				end
				S_CHECK, S_SEARCH: begin
					if (state_q == S_CHECK && query_q > rdata.cum_dist) begin
						element_index <= '0;
						point_x       <= '0;
						point_y       <= '0;
						point_z       <= '0;
						status        <= STATUS_BEYOND;
						done          <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						top_q   <= nt;
						bot_q   <= nb;
						state_q <= S_WAIT;
						if (nt < nb) begin
							mid_q   <= nmid;
							raddr_q <= nmid + AW'(1);
							ret_q   <= S_SEARCH;
						end else begin
							raddr_q <= nt;
							ret_q   <= S_TOP;
						end
					end
				end
				S_TOP: begin
					lo_q    <= rdata;
					raddr_q <= top_q + AW'(1);
					ret_q   <= S_BOT;
					state_q <= S_WAIT;
				end
				S_BOT: begin
					hi_q <= rdata;
					if (degen) begin
						element_index <= '0;
						point_x       <= '0;
						point_y       <= '0;
						point_z       <= '0;
						status        <= STATUS_DEGEN;
						done          <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						off_q       <= off_c[31:0];
						len_q       <= len_c[31:0];
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						lerp_start_q <= 1'b1;
						state_q      <= S_LERP;
					end
				end
				S_LERP: begin
					if (lerp_done) begin
						element_index <= top_ext[9:0];
						point_x       <= px;
						point_y       <= py;
						point_z       <= pz;
						status        <= STATUS_OK;
						done          <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	alp_frac_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.off   (off_q),
		.len   (len_q),
		.done  (div_done),
		.frac  (frac)
	);

	alp_lerp u_lerp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (lerp_start_q),
		.frac  (frac),
		.lo    (lo_q),
		.hi    (hi_q),
		.done  (lerp_done),
		.px    (px),
		.py    (py),
		.pz    (pz)
	);

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result transfer while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |->
			(element_index == '0 && point_x == '0 && point_y == '0 && point_z == '0))
		else $error("failed locate carries nonzero fields");

	a_locate_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode) |=> busy)
		else $error("locate accepted but sequencer did not start");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode) |=> (!busy && !done))
		else $error("load produced activity");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (top_q <= bot_q && bot_q < n_q))
		else $error("search interval out of range");

endmodule

`default_nettype wire

// ----- src/alp_node_ram.sv -----
`default_nettype none

module alp_node_ram
	import alp_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	parameter int AW        = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire node_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output node_t              rdata
);

	node_t mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data follows in the cycle after the address
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/alp_frac_div.sv -----
`default_nettype none

module alp_frac_div
	import alp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] off,
	input  wire logic [31:0] len,
	output logic             done,
	output logic      [16:0] frac
);

	// floor(off * 65536 / len), saturated at 1.0; one quotient bit per cycle
	logic        run_q;
	logic [3:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] len_q;
	logic [15:0] quo_q;

	logic [32:0] rem2;
	logic [32:0] diff;
	logic        qbit;
	logic [15:0] quo_next;

	always_comb begin
		rem2     = {rem_q, 1'b0};
		diff     = rem2 - {1'b0, len_q};
		qbit     = (rem2 >= {1'b0, len_q});
		quo_next = {quo_q[14:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				len_q <= len;
				if (off >= len) begin
					frac  <= FRAC_ONE;
					done  <= 1'b1;
					run_q <= 1'b0;
				end else begin
					rem_q <= off;
					quo_q <= '0;
					cnt_q <= '0;
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				rem_q <= qbit ? diff[31:0] : rem2[31:0];
				quo_q <= quo_next;
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					run_q <= 1'b0;
					done  <= 1'b1;
					frac  <= {1'b0, quo_next};
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/alp_lerp.sv -----
`default_nettype none

module alp_lerp
	import alp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic        [16:0] frac,
	input  wire node_t              lo,
	input  wire node_t              hi,
	output logic                    done,
	output logic signed      [31:0] px,
	output logic signed      [31:0] py,
	output logic signed      [31:0] pz
);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// one shared multiplier used for each axis in turn: multiply, then truncate and add
	logic               run_q;
	logic               phase_q;
	logic [1:0]         axis_q;
	logic [16:0]        frac_q;
	logic signed [50:0] prod_q;

	logic signed [31:0] a_lo;
	logic signed [31:0] a_hi;
	logic signed [32:0] delta;
	logic signed [50:0] prod_c;
	logic signed [50:0] biased;
	logic signed [50:0] shifted;
	logic        [31:0] pnt;

	always_comb begin
		case (axis_q)
			AXIS_X: begin
				a_lo = lo.x;
				a_hi = hi.x;
			end
			AXIS_Y: begin
				a_lo = lo.y;
				a_hi = hi.y;
			end
			default: begin
				a_lo = lo.z;
				a_hi = hi.z;
			end
		endcase
		delta   = 33'(a_hi) - 33'(a_lo);
		// 33 x 18 signed product, sign-extended to the result width
		prod_c  = 51'(delta) * 51'($signed({1'b0, frac_q}));
		// truncate toward zero on the divide by 65536
		biased  = prod_q + (prod_q[50] ? 51'sd65535 : 51'sd0);
		shifted = biased >>> 16;
		pnt     = a_lo + shifted[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= 1'b0;
			axis_q  <= AXIS_X;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				frac_q  <= frac;
				axis_q  <= AXIS_X;
				phase_q <= 1'b0;
				run_q   <= 1'b1;
			end else if (run_q) begin
				if (!phase_q) begin
					prod_q  <= prod_c;
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					case (axis_q)
						AXIS_X:  px <= pnt;
						AXIS_Y:  py <= pnt;
						default: pz <= pnt;
					endcase
					if (axis_q == AXIS_Z) begin
						run_q <= 1'b0;
						done  <= 1'b1;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/arc_length_point_locator_tb.sv -----
`timescale 1ns / 100ps

module arc_length_point_locator_tb
	import alp_pkg::*;
;

	localparam int MAX_NODES     = 1024;
	localparam int SETTLE_CYCLES = 64;    // longer than the worst-case locate
	localparam int STALL_LIMIT   = 5000;  // cycles with no transfer at all

	localparam logic       MODE_LOAD   = 1'b0;
	localparam logic       MODE_LOCATE = 1'b1;
	localparam logic [2:0] ADDR_ELEMENT_COUNT = 3'd0;  // register 0, byte address 0

	// one command as driven onto the input ports
	typedef struct packed {
		logic        mode;
		logic [9:0]  slot;
		node_t       node;
		logic [31:0] query;
	} cmd_t;

	// one locate result
	typedef struct packed {
		logic [9:0]         elem;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [1:0]         stat;
	} located_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	cmd_t        cur_cmd = '0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;

	logic               busy;
	logic               done;
	logic [9:0]         element_index;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [1:0]         status;
	logic [31:0]        prdata;
	logic               pready;

	// predictor state: node table and element count as the block should hold them
	node_t       node_tab [MAX_NODES];
	logic [9:0]  count_reg = 10'd1;

	// stimulus side: distances as planned, to aim queries at real elements
	logic [31:0] plan_dist [MAX_NODES];

	cmd_t     queued_cmds[$];
	located_t pending_points[$];

	bit cmd_taken = 1'b0;
	bit hold_for_drain = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_cycles = 0;
	int err_count = 0;

	arc_length_point_locator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (cur_cmd.mode),
		.node_index     (cur_cmd.slot),
		.node_distance  (cur_cmd.node.cum_dist),
		.node_x         (cur_cmd.node.x),
		.node_y         (cur_cmd.node.y),
		.node_z         (cur_cmd.node.z),
		.query_distance (cur_cmd.query),
		.done           (done),
		.element_index  (element_index),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_z        (point_z),
		.status         (status),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// top + trunc((bottom - top) * frac / 1.0), wrapped to 32 bits
	function automatic logic signed [31:0] lerp_axis(logic signed [31:0] top_v,
			logic signed [31:0] bot_v, longint frac);
		longint base, delta, shift;
		base  = top_v;
		delta = longint'(bot_v) - base;
		shift = (delta * frac) / 65536;  // truncates toward zero
		return 32'(base + shift);
	endfunction

	function automatic located_t locate_point(logic [31:0] q);
		located_t    r;
		int unsigned n, lo, hi, mid;
		longint      span, offs, frac;
		r = '0;
		r.stat = STATUS_OK;
		n = count_reg;
		if (n == 0)
			n = 1;                 // zero count acts as one element
		if (n > MAX_NODES - 1)
			n = MAX_NODES - 1;
		if (q > node_tab[n].cum_dist) begin
			r.stat = STATUS_BEYOND;
			return r;
		end
		// first element whose bottom distance is not below q
		lo = 0;
		hi = n - 1;
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (node_tab[mid + 1].cum_dist < q)
				lo = mid + 1;
			else
				hi = mid;
		end
		span = longint'({32'd0, node_tab[lo + 1].cum_dist})
			- longint'({32'd0, node_tab[lo].cum_dist});
		offs = longint'({32'd0, q}) - longint'({32'd0, node_tab[lo].cum_dist});
		if (span <= 0 || offs < 0) begin
			r.stat = STATUS_DEGEN;
			return r;
		end
		frac = (offs * 65536) / span;
		if (frac > 65536)
			frac = 65536;          // offset past bottom on a non-monotonic table
		r.elem = 10'(lo);
		r.px = lerp_axis(node_tab[lo].x, node_tab[lo + 1].x, frac);
		r.py = lerp_axis(node_tab[lo].y, node_tab[lo + 1].y, frac);
		r.pz = lerp_axis(node_tab[lo].z, node_tab[lo + 1].z, frac);
		return r;
	endfunction

	// ---------------------------------------------------------------- driver

	// mostly short gaps, a few long ones, and bursts with none
	function automatic int next_gap();
		int unsigned r;
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = int'($urandom_range(8, 40));
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(4, 40));
	endfunction

	// start holds until a transfer; then gap, optional drain pause, next command
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || cmd_taken) begin
			cmd_taken = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (hold_for_drain && pending_points.size() != 0) begin
				start <= 1'b0;
			end else if (queued_cmds.size() != 0) begin
				cur_cmd <= queued_cmds.pop_front();
				start <= 1'b1;
				gap_left = next_gap();
				hold_for_drain = ($urandom_range(0, 59) == 0);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : monitor
		located_t want;
		bit       moved;
		if (arst_n) begin
			moved = 1'b0;
			// result first: a new locate may be taken at the same edge
			if (done) begin
				moved = 1'b1;
				if (pending_points.size() == 0) begin
					$error("result transfer with no locate pending");
					err_count++;
				end else begin
					want = pending_points.pop_front();
					if (element_index !== want.elem) begin
						$error("element_index: expected %0d, got %0d", want.elem, element_index);
						err_count++;
					end
					if (point_x !== want.px) begin
						$error("point_x: expected %0d, got %0d", want.px, point_x);
						err_count++;
					end
					if (point_y !== want.py) begin
						$error("point_y: expected %0d, got %0d", want.py, point_y);
						err_count++;
					end
					if (point_z !== want.pz) begin
						$error("point_z: expected %0d, got %0d", want.pz, point_z);
						err_count++;
					end
					if (status !== want.stat) begin
						$error("status: expected %0d, got %0d", want.stat, status);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				cmd_taken = 1'b1;
				if (cur_cmd.mode == MODE_LOAD)
					node_tab[cur_cmd.slot] = cur_cmd.node;
				else
					pending_points.push_back(locate_point(cur_cmd.query));
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("arc_length_point_locator_tb NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [31:0] rand_coord();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 32'h7FFF_FFFF;
		if (r == 1)
			return 32'h8000_0000;
		return $urandom();
	endfunction

	task automatic push_load(logic [9:0] slot, logic [31:0] d, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		cmd_t c;
		c.mode  = MODE_LOAD;
		c.slot  = slot;
		c.node  = {d, x, y, z};
		c.query = $urandom();      // ignored on a load
		plan_dist[slot] = d;
		queued_cmds.push_back(c);
	endtask

	task automatic push_locate(logic [31:0] q);
		cmd_t c;
		c.mode  = MODE_LOCATE;
		c.slot  = 10'($urandom());  // node fields ignored on a locate
		c.node  = {$urandom(), $urandom(), $urandom(), $urandom()};
		c.query = q;
		queued_cmds.push_back(c);
	endtask

	// fresh table for nodes 0..last: rising distances with some flat
	// elements and a few wild nodes that break the ordering
	task automatic plan_table(int unsigned last);
		longint unsigned d, max_step, step;
		int unsigned     r;
		d = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom() >> 1);
		max_step = (64'hFFFF_FFFF - d) / last;
		for (int unsigned i = 0; i <= last; i++) begin
			if ($urandom_range(0, 29) == 0)
				push_load(10'(i), $urandom(), rand_coord(), rand_coord(), rand_coord());
			else
				push_load(10'(i), 32'(d), rand_coord(), rand_coord(), rand_coord());
			r = $urandom_range(0, 11);
			if (r == 0)
				step = 0;
			else if (r == 1)
				step = $urandom_range(1, 3);
			else
				step = $urandom_range(0, 32'(max_step));
			d += step;
		end
	endtask

	// mostly locates aimed inside elements; some beyond, some below, some reloads
	task automatic plan_traffic(int unsigned last, int unsigned items);
		int unsigned r, e;
		logic [31:0] lo_d, hi_d, q;
		for (int unsigned k = 0; k < items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 7) begin
				push_load(10'($urandom()), $urandom(), rand_coord(), rand_coord(), rand_coord());
			end else if (r < 15) begin
				if (plan_dist[last] == 32'hFFFF_FFFF)
					q = $urandom();
				else
					q = plan_dist[last] + 1
						+ $urandom_range(0, 32'hFFFF_FFFF - plan_dist[last] - 1);
				push_locate(q);
			end else if (r < 20) begin
				push_locate($urandom_range(0, plan_dist[0]));
			end else begin
				e = $urandom_range(0, last - 1);
				lo_d = plan_dist[e];
				hi_d = plan_dist[e + 1];
				if ($urandom_range(0, 4) == 0)
					q = hi_d;                      // exactly on a node
				else if (hi_d >= lo_d)
					q = lo_d + $urandom_range(0, hi_d - lo_d);
				else
					q = hi_d + $urandom_range(0, lo_d - hi_d);
				push_locate(q);
			end
		end
	endtask

	// everything sent and answered, then let the block settle
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (queued_cmds.size() != 0 || start || pending_points.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of element_count, then read it back
	task automatic write_count(logic [9:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ELEMENT_COUNT;
		pwdata  <= {22'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		count_reg = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[9:0] !== val) begin
			$error("element_count: expected %0d, got %0d", val, prdata[9:0]);
			err_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	// per phase: element count, whether to load a fresh table, traffic items.
	// count 1023 fills the whole table once; the later phases lean on it.
	int unsigned ph_count [10] = '{2, 0, 1023, 1, 9, 200, 3, 1023, 64, 1};
	bit          ph_fresh [10] = '{1, 1, 1,    0, 1, 1,   1, 0,    1,  1};
	int unsigned ph_items [10] = '{60, 40, 110, 40, 60, 70, 50, 70, 70, 40};

	initial begin
		int unsigned last;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, element_count at its reset value of one
		push_load(10'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		push_load(10'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_locate(32'h0000_0000);  // below the first node: negative offset
		push_locate(32'h0001_0000);  // on the top node, fraction zero
		push_locate(32'h0001_8000);  // a quarter in
		push_locate(32'h0003_0000);  // on the bottom node, fraction one
		push_locate(32'h0003_0001);  // just beyond the line
		push_locate(32'hFFFF_FFFF);  // far beyond
		push_load(10'd1, 32'h0001_0000, 32'h0000_1234, 32'hFFFF_0000, 32'h0001_0000);
		push_locate(32'h0001_0000);  // zero-length element
		push_load(10'd0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
		push_load(10'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hEDCB_A988);
		push_locate(32'hFFFF_FFFF);  // full-range element, end point
		push_locate(32'h0000_0001);  // tiny offset, fraction rounds to zero
		push_locate(32'h8000_0000);  // about half way, widest deltas
		push_load(10'h3FF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		push_locate(32'h7FFF_FFFF);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			last = (ph_count[p] == 0) ? 1 : ph_count[p];
			write_count(10'(ph_count[p]));
			if (ph_fresh[p])
				plan_table(last);
			plan_traffic(last, ph_items[p]);
			wait_drained();
		end

		if (err_count == 0)
			$display("arc_length_point_locator_tb OK");
		else
			$display("arc_length_point_locator_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/alp_pkg.sv
src/alp_node_ram.sv
src/alp_frac_div.sv
src/alp_lerp.sv
src/arc_length_point_locator.sv
tb/sv/arc_length_point_locator_tb.sv
